// ----- rtl/core/bls_pkg.sv -----
// Package for the bounded LIFO stack: operation and status codes, defaults,
// and the command word passed from the controller to the datapath.
// No dependencies.
package bls_pkg;

  // Field widths fixed by the interface
  localparam int unsigned OpW    = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned CapW   = 7;
  localparam int unsigned StatW  = 2;

  // Built depth of the entry store
  localparam int unsigned DEF_MAX_DEPTH = 64;

  // Capacity after reset
  localparam logic [CapW-1:0] CAP_RESET = 7'd64;

  // Word returned for a push or a failed operation
  localparam logic [DataW-1:0] FAIL_VALUE = 32'hFFFF_FFFF;

  // Operation codes
  localparam logic [OpW-1:0] OP_PUSH = 2'd0;
  localparam logic [OpW-1:0] OP_POP  = 2'd1;
  localparam logic [OpW-1:0] OP_PEEK = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatW-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [StatW-1:0] ST_INVALID   = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;    // carry out the operation on the input word
    logic cfg_wr;  // load the capacity register
  } cmd_t;

endpackage

// ----- rtl/core/bls_ctrl.sv -----
// Controller of the bounded LIFO stack: command handshake, result strobe
// and configuration handshake. Depends on bls_pkg.
module bls_ctrl
  import bls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic cfg_valid_i,
  output logic busy_o,
  output logic cfg_ready_o,
  output logic done_o,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_q, state_d;

  // The datapath takes a new command every cycle, even while a result is shown
  assign busy_o = 1'b0;

  // Capacity may only be loaded while no result is pending and no command is offered
  assign cfg_ready_o = (state_q == ST_IDLE) & ~start_i;

  assign cmd_o.exec   = start_i & ~busy_o;
  assign cmd_o.cfg_wr = cfg_valid_i & cfg_ready_o;

  // A result follows every accepted command in the next cycle
  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = cmd_o.exec ? ST_RESP : ST_IDLE;
      ST_RESP: state_d = cmd_o.exec ? ST_RESP : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign done_o = (state_q == ST_RESP);

endmodule

// ----- rtl/core/bls_datapath.sv -----
// Datapath of the bounded LIFO stack: entry store, entry count, capacity
// register and the result registers. Depends on bls_pkg.
module bls_datapath
  import bls_pkg::*;
#(
  parameter int unsigned MaxDepth = DEF_MAX_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic [CapW-1:0]         cfg_data_i,
  input  logic [OpW-1:0]          operation_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic [PosW-1:0]         depth_from_top_i,
  output logic signed [DataW-1:0] read_value_o,
  output logic [StatW-1:0]        status_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  localparam int unsigned CntW  = $clog2(MaxDepth + 1);
  localparam int unsigned AddrW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;

  logic [CapW-1:0]   cap_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   cap_eff;
  logic [CntW-1:0]   cnt_next;
  logic [CmpW-1:0]   cnt_w, pos_w;
  logic [AddrW-1:0]  waddr, raddr;
  logic              we, re;
  logic [StatW-1:0]  stat_d;

  logic [DataW-1:0]  mem_q [MaxDepth];
  logic [DataW-1:0]  rdata_q;
  logic              rd_ok_q;
  logic [StatW-1:0]  status_q;
  logic              empty_q, full_q;

  // Effective capacity: zero acts as one, and it never exceeds the built depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (int'(cap_q) > int'(MaxDepth)) begin
      cap_eff = CntW'(MaxDepth);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  assign cnt_w = CmpW'(count_q);
  assign pos_w = CmpW'(depth_from_top_i);

  // Decode the operation against the present count
  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    stat_d   = ST_OK;
    cnt_next = count_q;
    waddr    = AddrW'(count_q);
    raddr    = AddrW'(count_q - 1'b1);
    unique case (operation_i)
      OP_PUSH: begin
        if (count_q >= cap_eff) begin
          stat_d = ST_OVERFLOW;
        end else begin
          we       = 1'b1;
          cnt_next = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (count_q == '0) begin
          stat_d = ST_UNDERFLOW;
        end else begin
          re       = 1'b1;
          cnt_next = count_q - 1'b1;
        end
      end
      OP_PEEK: begin
        if (depth_from_top_i == '0 || pos_w > cnt_w) begin
          stat_d = ST_INVALID;
        end else begin
          re    = 1'b1;
          raddr = AddrW'(cnt_w - pos_w);
        end
      end
      default: stat_d = ST_INVALID;
    endcase
  end

  assign count_d = cmd_i.exec ? cnt_next : count_q;

  // Control registers: capacity and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
    end else begin
      if (cmd_i.cfg_wr) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
    end
  end

  // Entry store with one write port and a registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem_q[waddr] <= push_value_i;
    end
    if (cmd_i.exec && re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Result registers, loaded with each command
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_ok_q  <= re;
      status_q <= stat_d;
      empty_q  <= (cnt_next == '0);
      full_q   <= (cnt_next >= cap_eff);
    end
  end

  assign read_value_o = rd_ok_q ? $signed(rdata_q) : $signed(FAIL_VALUE);
  assign status_o     = status_q;
  assign is_empty_o   = empty_q;
  assign is_full_o    = full_q;

  // The count never passes the built depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(MaxDepth))
    else $error("entry count beyond built depth");

  // A successful push raises the count by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && we) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not advance the count");

  // The empty flag of a result matches the count it leaves behind
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (empty_q == (count_q == '0)))
    else $error("empty flag disagrees with count");

endmodule

// ----- rtl/core/bounded_lifo_stack_core.sv -----
// Top level of the bounded LIFO stack: joins the controller and datapath.
// Depends on bls_pkg, bls_ctrl and bls_datapath.
//
//  channel   handshake               word
//  command   start_i, busy_o         operation_i, push_value_i, depth_from_top_i
//  result    done_o (one cycle)      read_value_o, status_o, is_empty_o, is_full_o
//  config    cfg_valid_i, cfg_ready_o cfg_data_i (capacity)
//
// A command is taken in every cycle; its result shows on done_o in the next cycle,
// from the registered read port of the entry store.
// Reset empties the stack and sets the capacity to 64; the store itself is
// not cleared, since only written entries are ever read.
// The receiver cannot stall: each result is valid for exactly one cycle.
// The capacity register is taken only while no result is pending and no
// command is offered.
module bounded_lifo_stack_core
  import bls_pkg::*;
#(
  parameter int unsigned MaxDepth = DEF_MAX_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [OpW-1:0]          operation_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic [PosW-1:0]         depth_from_top_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] read_value_o,
  output logic [StatW-1:0]        status_o,
  output logic                    is_empty_o,
  output logic                    is_full_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CapW-1:0]         cfg_data_i
);

  cmd_t cmd;

  // Sequencing of commands, results and configuration
  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy_o),
    .cfg_ready_o (cfg_ready_o),
    .done_o      (done_o),
    .cmd_o       (cmd)
  );

  // Stack storage and result formation
  bls_datapath #(
    .MaxDepth (MaxDepth)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .push_value_i     (push_value_i),
    .depth_from_top_i (depth_from_top_i),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for bounded_lifo_stack_core: directed and random command words
// with random gaps, checked against a predictor of the stack, across several capacities.
// Depends on bls_pkg and the RTL of bounded_lifo_stack_core.
module testbench;
  import bls_pkg::*;

  // Operation code with no meaning; the block must answer it as invalid.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
  } stack_cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [StatW-1:0]        status;
    logic                    empty;
    logic                    full;
  } stack_answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [OpW-1:0]          operation_i = OP_PUSH;
  logic signed [DataW-1:0] push_value_i = '0;
  logic [PosW-1:0]         depth_from_top_i = '0;
  logic                    done_o;
  logic signed [DataW-1:0] read_value_o;
  logic [StatW-1:0]        status_o;
  logic                    is_empty_o;
  logic                    is_full_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CapW-1:0]         cfg_data_i = '0;

  // Predictor state: the entries, how many are held and the capacity register.
  logic [DataW-1:0] stack_mem [DEF_MAX_DEPTH];
  int unsigned      stack_count = 0;
  logic [CapW-1:0]  stack_cap = CAP_RESET;

  // Count as the stimulus generator expects it, used to aim peeks at held entries.
  int unsigned gen_depth = 0;
  int unsigned gen_lim = DEF_MAX_DEPTH;

  stack_cmd_t    cmd_backlog [$];
  stack_answer_t answers_due [$];
  stack_cmd_t    cur_cmd;
  int            gap_left = 0;
  bit            burst = 1'b0;
  int            mismatches = 0;

  bounded_lifo_stack_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .push_value_i     (push_value_i),
    .depth_from_top_i (depth_from_top_i),
    .done_o           (done_o),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A capacity of zero behaves as one; anything above the built depth is clipped to it.
  function automatic int unsigned cap_limit(logic [CapW-1:0] cap);
    if (cap == '0) return 1;
    if (cap > DEF_MAX_DEPTH) return DEF_MAX_DEPTH;
    return int'(unsigned'(cap));
  endfunction

  // Carries out one operation on the predictor state and returns the answer it gives.
  function automatic stack_answer_t stack_step_answer(stack_cmd_t c);
    stack_answer_t ans;
    int unsigned   lim;
    lim = cap_limit(stack_cap);
    ans.data = FAIL_VALUE;
    ans.status = ST_OK;
    case (c.op)
      OP_PUSH: begin
        if (stack_count >= lim) begin
          ans.status = ST_OVERFLOW;
        end else begin
          stack_mem[stack_count] = c.value;
          stack_count++;
        end
      end
      OP_POP: begin
        if (stack_count == 0) begin
          ans.status = ST_UNDERFLOW;
        end else begin
          stack_count--;
          ans.data = stack_mem[stack_count];
        end
      end
      OP_PEEK: begin
        if (c.pos == '0 || c.pos > stack_count) begin
          ans.status = ST_INVALID;
        end else begin
          ans.data = stack_mem[stack_count - c.pos];
        end
      end
      default: begin
        ans.status = ST_INVALID;
      end
    endcase
    ans.empty = (stack_count == 0);
    ans.full = (stack_count >= lim);
    return ans;
  endfunction

  // Driver: presents one word at a time and holds it until the block takes it.
  always @(posedge clk_i) begin
    logic drive;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      drive = start_i;
      if (start_i && !busy_o) begin
        answers_due.push_back(stack_step_answer(cur_cmd));
        drive = 1'b0;
      end
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          operation_i <= cur_cmd.op;
          push_value_i <= cur_cmd.value;
          depth_from_top_i <= cur_cmd.pos;
          drive = 1'b1;
          // Runs of back-to-back words alternate with runs of random gaps.
          if ($urandom_range(0, 29) == 0) burst = !burst;
          gap_left = burst ? 0 : int'($urandom_range(0, 18));
        end
      end
      start_i <= drive;
    end
  end

  task automatic report_field(input string name, input logic [DataW-1:0] want,
                              input logic [DataW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Monitor: every result word is held for one cycle and taken at the edge that ends it.
  always @(posedge clk_i) begin
    stack_answer_t want;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected none actual %h/%0d",
                 $time, read_value_o, status_o);
      end else begin
        want = answers_due.pop_front();
        report_field("read_value", want.data, read_value_o);
        report_field("status", DataW'(want.status), DataW'(status_o));
        report_field("is_empty", DataW'(want.empty), DataW'(is_empty_o));
        report_field("is_full", DataW'(want.full), DataW'(is_full_o));
      end
    end
  end

  // Queues one command word and keeps the generator's idea of the count up to date.
  task automatic queue_cmd(input logic [OpW-1:0] op, input logic [DataW-1:0] value,
                           input logic [PosW-1:0] pos);
    stack_cmd_t c;
    c.op = op;
    c.value = value;
    c.pos = pos;
    cmd_backlog.push_back(c);
    if (op == OP_PUSH && gen_depth < gen_lim) gen_depth++;
    if (op == OP_POP && gen_depth > 0) gen_depth--;
  endtask

  // Random words: unused codes at two percent, pushes at the given share, pops and peeks share the rest.
  task automatic queue_random_cmds(input int n, input int push_pct);
    int               roll;
    logic [OpW-1:0]   op;
    logic [DataW-1:0] value;
    logic [PosW-1:0]  pos;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_UNUSED;
      else if (roll < 2 + push_pct) op = OP_PUSH;
      else op = $urandom_range(0, 1) ? OP_POP : OP_PEEK;
      case ($urandom_range(0, 9))
        0: value = 32'h7FFF_FFFF;
        1: value = 32'h8000_0000;
        2: value = '0;
        3: value = '1;
        default: value = $urandom;
      endcase
      roll = $urandom_range(0, 9);
      if (roll == 0) pos = '0;
      else if (roll < 3) pos = PosW'($urandom_range(gen_depth + 1, 127));
      else if (gen_depth > 0) pos = PosW'($urandom_range(1, gen_depth));
      else pos = PosW'($urandom_range(0, 127));
      queue_cmd(op, value, pos);
    end
  endtask

  // Waits until every word has been taken and every result has come back.
  task automatic wait_stack_idle();
    do @(negedge clk_i);
    while (cmd_backlog.size() > 0 || start_i || answers_due.size() > 0);
  endtask

  // Writes the capacity register while the stack is idle.
  task automatic write_capacity(input logic [CapW-1:0] cap);
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    cfg_data_i <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    stack_cap = cap;
    gen_lim = cap_limit(cap);
    @(negedge clk_i);
  endtask

  // Phases: directed words at the reset capacity, then random words at a range of capacities.
  initial begin
    logic [CapW-1:0] caps [8];
    int              push_share [8];
    caps = '{7'd1, 7'd0, 7'd127, 7'd4, 7'd64, 7'd2, 7'd100, 7'd33};
    push_share = '{50, 50, 85, 40, 90, 30, 60, 50};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty stack, extreme values, every peek case and draining back to empty.
    queue_cmd(OP_POP, 32'h1234_5678, 7'd0);
    queue_cmd(OP_PEEK, '0, 7'd1);
    queue_cmd(OP_UNUSED, '1, 7'd1);
    queue_cmd(OP_PUSH, 32'h7FFF_FFFF, 7'd0);
    queue_cmd(OP_PUSH, 32'h8000_0000, 7'd127);
    queue_cmd(OP_PUSH, '0, 7'd0);
    queue_cmd(OP_PUSH, '1, 7'd0);
    queue_cmd(OP_PEEK, '0, 7'd0);
    queue_cmd(OP_PEEK, '0, 7'd1);
    queue_cmd(OP_PEEK, '0, 7'd4);
    queue_cmd(OP_PEEK, '0, 7'd5);
    queue_cmd(OP_PEEK, '0, 7'd127);
    queue_cmd(OP_UNUSED, 32'h5555_AAAA, 7'd2);
    queue_cmd(OP_POP, '0, 7'd0);
    queue_cmd(OP_POP, '0, 7'd0);
    queue_cmd(OP_POP, '0, 7'd0);
    queue_cmd(OP_POP, '0, 7'd0);
    queue_cmd(OP_POP, '1, 7'd127);
    wait_stack_idle();

    // Fixed capacities first, a lowered capacity over a filled stack among them.
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      queue_random_cmds(120, push_share[p]);
      wait_stack_idle();
    end
    for (int p = 0; p < 4; p++) begin
      write_capacity(CapW'($urandom_range(0, 127)));
      queue_random_cmds(120, $urandom_range(30, 80));
      wait_stack_idle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
